// File: rtl/onset_detect_tempo_estimate_defines.svh
// Assertion macros for the onset detector and tempo estimator.
// Included by the RTL files that carry concurrent assertions.
`ifndef ONSET_DETECT_TEMPO_ESTIMATE_DEFINES_SVH
`define ONSET_DETECT_TEMPO_ESTIMATE_DEFINES_SVH
`ifndef SYNTHESIS
`define ODTE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("odte: assertion failed");
`define ODTE_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("odte: forbidden condition");
`else
`define ODTE_ASSERT(lbl, clk, rst, prop)
`define ODTE_NEVER(lbl, clk, rst, expr)
`endif
`endif

// File: rtl/odte_pkg.sv
// Shared constants, register indexes and control/status types for the
// onset detector and tempo estimator. No dependencies.
`default_nettype none
package odte_pkg;
   localparam int WIN_LEN   = 32;
   localparam int WIN_AW    = $clog2(WIN_LEN);
   localparam int WFILL_W   = $clog2(WIN_LEN + 1);
   localparam int SUM_W     = 37;
   localparam int OH_LEN    = 16;
   localparam int OH_AW     = $clog2(OH_LEN);
   localparam int OFILL_W   = $clog2(OH_LEN + 1);
   localparam int HIST_BINS = 201;
   localparam int HIST_AW   = 8;
   localparam int HCNT_W    = 4;
   localparam int SMOOTH_W  = 6;
   localparam int LHS_W     = 38;
   localparam int RHS_W     = 49;
   localparam int D_W       = 46;
   localparam int N_W       = 24;
   localparam int DIV_W     = 54;
   localparam int Q_W       = 8;

   localparam logic [7:0] BPM_LO = 8'd40;
   localparam logic [7:0] BPM_HI = 8'd240;
   localparam logic [N_W-1:0] SEC_PER_MIN = N_W'(60);
   localparam logic [OFILL_W-1:0] MIN_ONSETS = OFILL_W'(4);

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LENGTH   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ONSET_GAP  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_GAIN = 8'd3;

   localparam logic [17:0] SAMPLE_RATE_RST    = 18'd44100;
   localparam logic [13:0] FRAME_LENGTH_RST   = 14'd1024;
   localparam logic [7:0]  MIN_ONSET_GAP_RST  = 8'd4;
   localparam logic [11:0] THRESHOLD_GAIN_RST = 12'd384;

   typedef struct packed {
      logic win_rd;
      logic sum_upd;
      logic mul;
      logic cmp;
      logic t_init;
      logic oh_rd;
      logic t_get;
      logic t_mul;
      logic div_load;
      logic div_step;
      logic hist_rd;
      logic hist_wr;
      logic t_next;
      logic scan_issue;
      logic t_set;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic onset;
      logic ofill_ok;
      logic i_first;
      logic i_last;
      logic rng_ok;
      logic any;
      logic scan_last;
      logic rsp_free;
   } sts_type;
endpackage
`default_nettype wire

// File: rtl/odte_dp.sv
// Datapath: config registers, HFC window, threshold compare, onset ring,
// interval divider, tempo histogram and result register. Uses odte_pkg.
`default_nettype none
`include "onset_detect_tempo_estimate_defines.svh"
module odte_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  odte_pkg::cmd_type                   cmd,
   output odte_pkg::sts_type                   sts,
   input  logic [31:0]                         req_hfc_value,
   input  logic                                csr_valid,
   input  logic [odte_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [odte_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_onset,
   output logic [7:0]                          rsp_tempo_bpm,
   output logic [31:0]                         rsp_frame_number
);
   import odte_pkg::*;

   logic [17:0] sr_ff;
   logic [13:0] flen_ff;
   logic [7:0]  mgap_ff;
   logic [11:0] gain_ff;

   logic [31:0]         win_mem [WIN_LEN];
   logic [31:0]         win_q_ff, hfc_ff;
   logic [SUM_W-1:0]    wsum_ff, wsum_in;
   logic [WFILL_W-1:0]  wfill_ff, wfill_in;
   logic [WIN_AW-1:0]   wptr_ff;
   logic [LHS_W-1:0]    lhs_ff;
   logic [RHS_W-1:0]    rhs_ff;
   logic                onset_det;
   logic [7:0]          gap_ff;
   logic [31:0]         frame_ff;
   logic                onset_ff;

   logic [31:0]         oh_mem [OH_LEN];
   logic [31:0]         oh_q_ff, prev_ff, frames_ff;
   logic [OH_AW-1:0]    optr_ff, oh_addr;
   logic [OFILL_W-1:0]  ofill_ff, ti_ff;

   logic [N_W-1:0]      n_ff;
   logic [D_W-1:0]      d_ff;
   logic [DIV_W-1:0]    n_ext, d40, d240, rem_ff, dsh_ff;
   logic [Q_W-1:0]      q_ff;

   logic [HCNT_W-1:0]   hist_mem [HIST_BINS];
   logic [HIST_BINS-1:0] hvalid_ff;
   logic [HCNT_W-1:0]   hq_ff, hq_val;
   logic                hvq_ff;
   logic [HIST_AW-1:0]  haddr, hbin, sa_ff, sq_ff;
   logic                sd_v_ff;
   logic [HCNT_W-1:0]   p1_ff, p2_ff;
   logic [SMOOTH_W-1:0] best_ff, smooth;
   logic [HIST_AW-1:0]  bestbin_ff;
   logic                any_ff;
   logic [7:0]          tempo_ff;
   logic                tempo_ok;
   logic                rsp_valid_ff;

   // window update
   always_comb begin
      if (wfill_ff == WFILL_W'(WIN_LEN)) begin
         wsum_in  = wsum_ff - SUM_W'(win_q_ff) + SUM_W'(hfc_ff);
         wfill_in = wfill_ff;
      end else begin
         wsum_in  = wsum_ff + SUM_W'(hfc_ff);
         wfill_in = wfill_ff + 1'b1;
      end
   end

   assign onset_det = (RHS_W'({lhs_ff, 8'b0}) > rhs_ff) && (gap_ff >= mgap_ff);

   assign oh_addr = optr_ff - ofill_ff[OH_AW-1:0] + ti_ff[OH_AW-1:0];

   assign n_ext = DIV_W'(n_ff);
   assign d40   = DIV_W'(d_ff) * DIV_W'(BPM_LO);
   assign d240  = DIV_W'(d_ff) * DIV_W'(BPM_HI);

   assign hbin  = q_ff - BPM_LO;
   assign haddr = cmd.hist_rd ? hbin : sa_ff;
   assign hq_val = hvq_ff ? hq_ff : '0;
   assign smooth = SMOOTH_W'(p2_ff) + SMOOTH_W'(p1_ff) + SMOOTH_W'(hq_val);

   assign tempo_ok = (tempo_ff == 8'd0) || ((tempo_ff >= BPM_LO) && (tempo_ff <= BPM_HI));

   assign sts.onset     = onset_ff;
   assign sts.ofill_ok  = ofill_ff >= MIN_ONSETS;
   assign sts.i_first   = ti_ff == '0;
   assign sts.i_last    = ti_ff == ofill_ff - 1'b1;
   assign sts.rng_ok    = (d_ff != '0) && (n_ext >= d40) && (n_ext <= d240);
   assign sts.any       = any_ff;
   assign sts.scan_last = sa_ff == HIST_AW'(HIST_BINS);
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;

   // memories and payload
   always_ff @(posedge clock) begin
      if (cmd.win_rd) begin
         hfc_ff   <= req_hfc_value;
         win_q_ff <= win_mem[wptr_ff];
      end
      if (cmd.sum_upd) win_mem[wptr_ff] <= hfc_ff;
      if (cmd.mul) begin
         lhs_ff <= LHS_W'(hfc_ff) * LHS_W'(wfill_ff);
         rhs_ff <= RHS_W'(wsum_ff) * RHS_W'(gain_ff);
      end
      if (cmd.cmp && onset_det) oh_mem[optr_ff] <= frame_ff;
      if (cmd.oh_rd) oh_q_ff <= oh_mem[oh_addr];
      if (cmd.t_init) n_ff <= N_W'(N_W'(sr_ff) * SEC_PER_MIN);
      if (cmd.t_get) begin
         prev_ff   <= oh_q_ff;
         frames_ff <= oh_q_ff - prev_ff;
      end
      if (cmd.t_mul) d_ff <= D_W'(D_W'(frames_ff) * D_W'(flen_ff));
      if (cmd.div_load) begin
         rem_ff <= DIV_W'({n_ff, 1'b0}) + DIV_W'(d_ff);
         dsh_ff <= DIV_W'({d_ff, 8'b0});
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         if (rem_ff >= dsh_ff) begin
            rem_ff <= rem_ff - dsh_ff;
            q_ff   <= {q_ff[Q_W-2:0], 1'b1};
         end else begin
            q_ff   <= {q_ff[Q_W-2:0], 1'b0};
         end
         dsh_ff <= dsh_ff >> 1;
      end
      if (cmd.hist_rd || cmd.scan_issue) begin
         if (haddr < HIST_AW'(HIST_BINS)) begin
            hq_ff  <= hist_mem[haddr];
            hvq_ff <= hvalid_ff[haddr];
         end else begin
            hvq_ff <= 1'b0;
         end
      end
      if (cmd.hist_wr) hist_mem[hbin] <= hq_val + 1'b1;
      if (cmd.scan_issue) sq_ff <= sa_ff;
      if (cmd.out_load) begin
         rsp_onset        <= onset_ff;
         rsp_tempo_bpm    <= tempo_ff;
         rsp_frame_number <= frame_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         sr_ff      <= SAMPLE_RATE_RST;
         flen_ff    <= FRAME_LENGTH_RST;
         mgap_ff    <= MIN_ONSET_GAP_RST;
         gain_ff    <= THRESHOLD_GAIN_RST;
         wsum_ff    <= '0;
         wfill_ff   <= '0;
         wptr_ff    <= '0;
         gap_ff     <= MIN_ONSET_GAP_RST;
         frame_ff   <= '0;
         onset_ff   <= 1'b0;
         optr_ff    <= '0;
         ofill_ff   <= '0;
         ti_ff      <= '0;
         any_ff     <= 1'b0;
         hvalid_ff  <= '0;
         sa_ff      <= '0;
         sd_v_ff    <= 1'b0;
         p1_ff      <= '0;
         p2_ff      <= '0;
         best_ff    <= '0;
         bestbin_ff <= '0;
         tempo_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SAMPLE_RATE:    sr_ff   <= csr_wdata[17:0];
               CSR_FRAME_LENGTH:   flen_ff <= csr_wdata[13:0];
               CSR_MIN_ONSET_GAP:  mgap_ff <= csr_wdata[7:0];
               CSR_THRESHOLD_GAIN: gain_ff <= csr_wdata[11:0];
               default: ;
            endcase
         end
         if (cmd.sum_upd) begin
            wsum_ff  <= wsum_in;
            wfill_ff <= wfill_in;
            wptr_ff  <= (wptr_ff == WIN_AW'(WIN_LEN - 1)) ? '0 : wptr_ff + 1'b1;
         end
         if (cmd.cmp) begin
            onset_ff <= onset_det;
            if (onset_det) begin
               gap_ff  <= '0;
               optr_ff <= optr_ff + 1'b1;
               if (ofill_ff != OFILL_W'(OH_LEN)) ofill_ff <= ofill_ff + 1'b1;
            end else if (gap_ff != 8'hFF) begin
               gap_ff <= gap_ff + 1'b1;
            end
         end
         if (cmd.t_init) begin
            ti_ff      <= '0;
            any_ff     <= 1'b0;
            hvalid_ff  <= '0;
            sa_ff      <= '0;
            p1_ff      <= '0;
            p2_ff      <= '0;
            best_ff    <= '0;
            bestbin_ff <= '0;
         end
         if (cmd.t_next) ti_ff <= ti_ff + 1'b1;
         if (cmd.hist_wr) begin
            hvalid_ff[hbin] <= 1'b1;
            any_ff          <= 1'b1;
         end
         if (cmd.scan_issue) sa_ff <= sa_ff + 1'b1;
         sd_v_ff <= cmd.scan_issue;
         // slide the three-bin window; center is one behind the returned bin
         if (sd_v_ff) begin
            p2_ff <= p1_ff;
            p1_ff <= hq_val;
            if (sq_ff != '0 && smooth > best_ff) begin
               best_ff    <= smooth;
               bestbin_ff <= sq_ff - 1'b1;
            end
         end
         if (cmd.t_set) tempo_ff <= bestbin_ff + BPM_LO;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
            frame_ff     <= frame_ff + 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `ODTE_NEVER(a_wfill_range, clock, reset, wfill_ff > WFILL_W'(WIN_LEN))
   `ODTE_ASSERT(a_tempo_range, clock, reset, tempo_ok)
   `ODTE_ASSERT(a_hist_rmw, clock, reset, cmd.hist_wr |-> $past(cmd.hist_rd))
   `ODTE_ASSERT(a_onset_gap, clock, reset, (cmd.cmp && onset_det) |=> (gap_ff == 8'd0))
endmodule
`default_nettype wire

// File: rtl/odte_ctrl.sv
// Sequencer for the onset detector: steps the datapath through window
// update, threshold test and tempo update. Uses odte_pkg.
`default_nettype none
module odte_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  odte_pkg::sts_type sts,
   output odte_pkg::cmd_type cmd
);
   import odte_pkg::*;

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_SUM  = 5'd1;
   localparam logic [4:0] ST_MUL  = 5'd2;
   localparam logic [4:0] ST_CMP  = 5'd3;
   localparam logic [4:0] ST_CHK  = 5'd4;
   localparam logic [4:0] ST_TCLR = 5'd5;
   localparam logic [4:0] ST_TRD  = 5'd6;
   localparam logic [4:0] ST_TGET = 5'd7;
   localparam logic [4:0] ST_TMUL = 5'd8;
   localparam logic [4:0] ST_TRNG = 5'd9;
   localparam logic [4:0] ST_TDIV = 5'd10;
   localparam logic [4:0] ST_THRD = 5'd11;
   localparam logic [4:0] ST_THWR = 5'd12;
   localparam logic [4:0] ST_TNXT = 5'd13;
   localparam logic [4:0] ST_SCAN = 5'd14;
   localparam logic [4:0] ST_SDRN = 5'd15;
   localparam logic [4:0] ST_TSET = 5'd16;
   localparam logic [4:0] ST_DONE = 5'd17;

   logic [4:0] state_ff, state_in;
   logic [2:0] dcnt_ff, dcnt_in;

   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      dcnt_in  = dcnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.win_rd = 1'b1;
               state_in   = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum_upd = 1'b1;
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: state_in = (sts.onset && sts.ofill_ok) ? ST_TCLR : ST_DONE;
         ST_TCLR: begin
            cmd.t_init = 1'b1;
            state_in   = ST_TRD;
         end
         ST_TRD: begin
            cmd.oh_rd = 1'b1;
            state_in  = ST_TGET;
         end
         ST_TGET: begin
            cmd.t_get = 1'b1;
            state_in  = sts.i_first ? ST_TNXT : ST_TMUL;
         end
         ST_TMUL: begin
            cmd.t_mul = 1'b1;
            state_in  = ST_TRNG;
         end
         ST_TRNG: begin
            if (sts.rng_ok) begin
               cmd.div_load = 1'b1;
               dcnt_in      = '0;
               state_in     = ST_TDIV;
            end else begin
               state_in = ST_TNXT;
            end
         end
         ST_TDIV: begin
            cmd.div_step = 1'b1;
            dcnt_in      = dcnt_ff + 1'b1;
            if (dcnt_ff == 3'd7) state_in = ST_THRD;
         end
         ST_THRD: begin
            cmd.hist_rd = 1'b1;
            state_in    = ST_THWR;
         end
         ST_THWR: begin
            cmd.hist_wr = 1'b1;
            state_in    = ST_TNXT;
         end
         ST_TNXT: begin
            if (sts.i_last) begin
               state_in = sts.any ? ST_SCAN : ST_DONE;
            end else begin
               cmd.t_next = 1'b1;
               state_in   = ST_TRD;
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (sts.scan_last) state_in = ST_SDRN;
         end
         ST_SDRN: state_in = ST_TSET;
         ST_TSET: begin
            cmd.t_set = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            // hold the result until the output register frees up
            if (sts.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         dcnt_ff  <= dcnt_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/onset_detect_tempo_estimate.sv
// Onset detector with inter-onset-interval tempo estimate.
// Input channel req_*: one HFC value per audio frame (valid/ready).
// Result channel rsp_*: one item per input: onset flag, current tempo in
// BPM (0 until the first estimate) and the frame index since reset.
// Config channel csr_*: register index 0..3 (sample rate, frame length,
// minimum onset gap, threshold gain); always ready, write only when idle.
// Without a tempo update an accepted item passes the window update,
// multiply, threshold compare and check steps before its result is loaded.
// On an onset with four or more onsets held, a tempo update follows: a
// start step and a read of the first entry, then per interval a read,
// difference, range check and, when in range, the bit-serial quotient
// divider and histogram update, and last the histogram scan.
// The sequencer works on one item at a time; the next item is taken as
// soon as the previous result is in the output register, even if the
// receiver has not yet taken it. A stalled receiver holds the finished
// item in the output register and the sequencer waits at the end of the
// following item.
// Reset: config returns to 44100 Hz, 1024 samples, gap 4, gain 1.5, the
// window, onset ring, counters and tempo are cleared; no clearing pass.
// Uses odte_pkg, odte_ctrl and odte_dp.
`default_nettype none
module onset_detect_tempo_estimate (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [31:0]                         req_hfc_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_onset,
   output logic [7:0]                          rsp_tempo_bpm,
   output logic [31:0]                         rsp_frame_number,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [odte_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [odte_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import odte_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   odte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   odte_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_hfc_value    (req_hfc_value),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_onset        (rsp_onset),
      .rsp_tempo_bpm    (rsp_tempo_bpm),
      .rsp_frame_number (rsp_frame_number)
   );
endmodule
`default_nettype wire
